/* rtl/grr_pkg.sv */
package grr_pkg;

  // Field and register widths
  localparam int ROW_IDX_W   = 6;
  localparam int COL_IDX_W   = 6;
  localparam int CELL_W      = 16;
  localparam int COUNT_W     = 7;
  localparam int SHIFT_W     = 30;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 30;

  // Dividend bits retired per remainder step
  localparam int DIGIT_W = 4;

  // Default sizes
  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_MAX_COLS    = 64;
  localparam int DEF_VALUE_WIDTH = 16;

  // Register reset values
  localparam logic [COUNT_W-1:0] ROW_COUNT_RESET    = 7'd64;
  localparam logic [COUNT_W-1:0] COLUMN_COUNT_RESET = 7'd64;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET        = '0;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } opcode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW_COUNT    = 2'd0,
    REG_COLUMN_COUNT = 2'd1,
    REG_SHIFT_AMOUNT = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GEO1,
    ST_GEO2,
    ST_GEO3,
    ST_GEO4,
    ST_MODS,
    ST_MODW,
    ST_SRC,
    ST_MAP,
    ST_READ,
    ST_RESP
  } state_t;

endpackage

/* rtl/grid_ring_rotator.sv */
// Write items complete in the transfer cycle; one write can be taken every cycle.
// A read of a rotating ring waits on the remainder unit, which retires four
// shift bits per cycle (eight steps).
// A read outside the rings or on a leftover centre skips the remainder unit; one outside the store skips the read;
// the next item is taken in the cycle after the result loads, and the load waits while the output is full.
// Synchronous active-high reset clears control, sets counts to 64 and shift to 0; grid undefined.
module grid_ring_rotator import grr_pkg::*; #(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [0:0]             opcode,
  input  logic [ROW_IDX_W-1:0]   row_index,
  input  logic [COL_IDX_W-1:0]   column_index,
  input  logic [CELL_W-1:0]      cell_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CELL_W-1:0]      rotated_value
);

  localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int DW0     = $clog2(MAX_DIM + 1);
  localparam int DIM_W   = (DW0 > COUNT_W) ? DW0 : COUNT_W;
  localparam int PER_W   = DIM_W + 2;
  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W  = $clog2(DEPTH);

  state_t state, state_next;

  logic [COUNT_W-1:0] row_count;
  logic [COUNT_W-1:0] column_count;
  logic [SHIFT_W-1:0] shift_amount;

  logic [DIM_W-1:0] row, col, n, m, layer, half, rmx, cmx, h, w, sr, sc;
  logic             act, rot, zero;
  logic [PER_W-1:0] p, pos, src;

  logic [DIM_W-1:0] n_clamp, m_clamp, rc, cc, layer_next, half_next, min_a, min_b;
  logic [DIM_W-1:0] rmx_next, cmx_next, sr_next, sc_next;
  logic             in_store, act_next, rotate;
  logic [PER_W-1:0] p_next, pos_next, src_next, h_e, w_e, hw, hhw;
  logic [PER_W:0]   t_sum, t_sub;

  logic              wr_en, rd_en, load, mod_start, mod_done;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [VALUE_WIDTH-1:0] wr_data, rd_data;
  logic [PER_W-1:0]  mod_rem;
  logic [31:0]       cell_wide, rd_wide;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= ROW_COUNT_RESET;
      column_count <= COLUMN_COUNT_RESET;
      shift_amount <= SHIFT_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_ROW_COUNT:    row_count    <= cfg_data[COUNT_W-1:0];
        REG_COLUMN_COUNT: column_count <= cfg_data[COUNT_W-1:0];
        REG_SHIFT_AMOUNT: shift_amount <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Write path straight into the store on transfer
  assign cell_wide = 32'(cell_value);
  assign wr_data   = cell_wide[VALUE_WIDTH-1:0];
  assign wr_addr   = ADDR_W'(ADDR_W'(row_index) * ADDR_W'(MAX_COLS) + ADDR_W'(column_index));
  assign wr_en     = in_valid && in_ready && (opcode == OP_WRITE) &&
                     (DIM_W'(row_index) < DIM_W'(MAX_ROWS)) &&
                     (DIM_W'(column_index) < DIM_W'(MAX_COLS));

  assign rd_addr = ADDR_W'(ADDR_W'(sr) * ADDR_W'(MAX_COLS) + ADDR_W'(sc));
  assign rd_wide = 32'(rd_data);

  // Saturate the counts into the store size; a zero count becomes one
  assign rc      = DIM_W'(row_count);
  assign cc      = DIM_W'(column_count);
  assign n_clamp = (rc == '0) ? DIM_W'(1) : ((rc > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rc);
  assign m_clamp = (cc == '0) ? DIM_W'(1) : ((cc > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cc);
  assign in_store = (row < DIM_W'(MAX_ROWS)) && (col < DIM_W'(MAX_COLS));

  // Ring index: distance to the nearest edge of the active grid
  always_comb begin
    logic [DIM_W-1:0] dr, dc;
    dr         = n - DIM_W'(1) - row;
    dc         = m - DIM_W'(1) - col;
    min_a      = (row < col) ? row : col;
    min_b      = (dr < dc) ? dr : dc;
    layer_next = (min_a < min_b) ? min_a : min_b;
    half_next  = ((n < m) ? n : m) >> 1;
    act_next   = (row < n) && (col < m);
  end

  // Ring bounds
  assign rotate   = act && (layer < half);
  assign rmx_next = n - DIM_W'(1) - layer;
  assign cmx_next = m - DIM_W'(1) - layer;

  // Perimeter and position along the ring path
  assign h_e    = PER_W'(h);
  assign w_e    = PER_W'(w);
  assign hw     = h_e + w_e;
  assign hhw    = hw + h_e;
  assign p_next = (h_e << 1) + (w_e << 1);

  always_comb begin
    if (col == layer && row < rmx) begin
      pos_next = PER_W'(row - layer);
    end else if (row == rmx && col < cmx) begin
      pos_next = h_e + PER_W'(col - layer);
    end else if (col == cmx && row > layer) begin
      pos_next = hw + PER_W'(rmx - row);
    end else begin
      pos_next = hhw + PER_W'(cmx - col);
    end
  end

  // Source position: pos minus the reduced shift, wrapped once
  assign t_sum    = {1'b0, pos} + {1'b0, p} - {1'b0, mod_rem};
  assign t_sub    = t_sum - {1'b0, p};
  assign src_next = (t_sum >= {1'b0, p}) ? t_sub[PER_W-1:0] : t_sum[PER_W-1:0];

  // Map source position back to row and column
  always_comb begin
    if (src < h_e) begin
      sr_next = layer + DIM_W'(src);
      sc_next = layer;
    end else if (src < hw) begin
      sr_next = rmx;
      sc_next = layer + DIM_W'(src - h_e);
    end else if (src < hhw) begin
      sr_next = rmx - DIM_W'(src - hw);
      sc_next = cmx;
    end else begin
      sr_next = layer;
      sc_next = cmx - DIM_W'(src - hhw);
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and controls
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    load       = 1'b0;
    mod_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && opcode == OP_READ) begin
          state_next = ST_GEO1;
        end
      end
      ST_GEO1: state_next = in_store ? ST_GEO2 : ST_RESP;
      ST_GEO2: state_next = ST_GEO3;
      ST_GEO3: state_next = rotate ? ST_GEO4 : ST_READ;
      ST_GEO4: state_next = ST_MODS;
      ST_MODS: begin
        mod_start  = 1'b1;
        state_next = ST_MODW;
      end
      ST_MODW: begin
        if (mod_done) begin
          state_next = ST_SRC;
        end
      end
      ST_SRC:  state_next = ST_MAP;
      ST_MAP:  state_next = ST_READ;
      ST_READ: begin
        rd_en      = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        load = !out_valid || out_ready;
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Working registers, advanced one stage per state
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          row <= DIM_W'(row_index);
          col <= DIM_W'(column_index);
        end
      end
      ST_GEO1: begin
        n    <= n_clamp;
        m    <= m_clamp;
        zero <= !in_store;
      end
      ST_GEO2: begin
        layer <= layer_next;
        half  <= half_next;
        act   <= act_next;
      end
      ST_GEO3: begin
        rot <= rotate;
        rmx <= rmx_next;
        cmx <= cmx_next;
        h   <= rmx_next - layer;
        w   <= cmx_next - layer;
        if (!rotate) begin
          sr <= row;
          sc <= col;
        end
      end
      ST_GEO4: begin
        p   <= p_next;
        pos <= pos_next;
      end
      ST_SRC: src <= src_next;
      ST_MAP: begin
        sr <= sr_next;
        sc <= sc_next;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rotated_value <= zero ? '0 : rd_wide[CELL_W-1:0];
    end
  end

  grr_mod_unit #(
    .DIV_W (PER_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (shift_amount),
    .divisor  (p),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  grr_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (VALUE_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == ST_MODW)
    else $error("remainder finished outside its wait state");

  a_src_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_MAP |-> src < p)
    else $error("source position beyond ring perimeter");

  a_src_on_ring: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ && rot |-> sr >= layer && sr <= rmx && sc >= layer && sc <= cmx)
    else $error("source cell off its ring");

endmodule

/* rtl/grr_store.sv */
module grr_store #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; hold data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/grr_mod_unit.sv */
module grr_mod_unit import grr_pkg::*; #(
  parameter int DIV_W = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SHIFT_W-1:0] dividend,
  input  logic [DIV_W-1:0]   divisor,
  output logic               done,
  output logic [DIV_W-1:0]   rem
);

  localparam int STEPS = (SHIFT_W + DIGIT_W - 1) / DIGIT_W;
  localparam int PAD_W = STEPS * DIGIT_W;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [PAD_W-1:0]  bits;
  logic [DIV_W-1:0]  div;
  logic [DIV_W-1:0]  rem_next;

  // Restoring remainder: per step, shift in DIGIT_W dividend bits one at a time, subtracting when it fits
  always_comb begin
    logic [DIV_W:0] acc;
    acc = {1'b0, rem};
    for (int i = 0; i < DIGIT_W; i++) begin
      acc = {acc[DIV_W-1:0], bits[PAD_W-1-i]};
      if (acc >= {1'b0, div}) begin
        acc = acc - {1'b0, div};
      end
    end
    rem_next = acc[DIV_W-1:0];
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  // Operands and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      bits <= PAD_W'(dividend);
      div  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      bits <= bits << DIGIT_W;
      rem  <= rem_next;
    end
  end

  a_last_step_done: assert property (@(posedge clk) disable iff (rst)
    busy && !start && cnt == '0 |=> done && !busy)
    else $error("remainder unit missed its done pulse");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("remainder unit done while still stepping");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    busy && $past(busy) |-> rem < div)
    else $error("partial remainder not below divisor");

endmodule
